// File: hw/rtl/trx_pkg.sv
// ----------------------------------------------------------------------------
// trx_pkg
// Shared types and constants of the three-register instruction executor.
// ----------------------------------------------------------------------------
package trx_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CMD_W      = 4;
	localparam int REG_IDX_W  = 2;
	localparam int MEM_ADDR_W = 7;
	localparam int TARGET_W   = 10;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 4'd0,
		CMD_MUL     = 4'd1,
		CMD_SUB     = 4'd2,
		CMD_DIV     = 4'd3,
		CMD_LOADIMM = 4'd4,
		CMD_LOAD    = 4'd5,
		CMD_STORE   = 4'd6,
		CMD_EQU     = 4'd7,
		CMD_LT      = 4'd8,
		CMD_GT      = 4'd9,
		CMD_JUMPZ   = 4'd10
	} cmd_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_EQ,
		ALU_LT
	} alu_op_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_SINGLE,
		A_MUL,
		A_MAGA,
		A_MAGB,
		A_DIV,
		A_FIX
	} alu_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_OP,
		S_WAIT
	} exe_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]             command;
		logic [REG_IDX_W-1:0]         dest_reg;
		logic [REG_IDX_W-1:0]         src_a_reg;
		logic [REG_IDX_W-1:0]         src_b_reg;
		logic signed [DATA_WIDTH-1:0] immediate;
		logic [MEM_ADDR_W-1:0]        mem_addr;
		logic [TARGET_W-1:0]          jump_target;
	} instr_t;

	typedef struct packed {
		logic                         jump_taken;
		logic [TARGET_W-1:0]          next_index;
		logic signed [DATA_WIDTH-1:0] written_value;
		logic                         divide_error;
	} result_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic                  done;
		logic [DATA_WIDTH-1:0] result;
	} alu_rsp_t;

endpackage

// File: hw/rtl/three_register_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// three_register_instruction_executor_top
// Executes one decoded instruction per transaction against a register file
// and a word data memory, reporting the written value and any taken jump.
//
// Channel   Direction  Handshake            Payload
// instr     in         start & !busy        instr_t
// result    out        done (one cycle)     result_t
//
// From accept the sequencer reads sources A and B, then in S_OP either
// emits the result for load immediate, load, store, jump and unused codes
// (and divide by zero), or starts the shared adder in trx_alu for add,
// subtract, compares, multiply and divide (one quotient bit per cycle).
// busy is high from accept until the strobe edge; the next transaction
// may be accepted in the cycle the strobe is shown.
// Reset clears both storage arrays through per-entry valid bits at once;
// the result side cannot stall.
// ----------------------------------------------------------------------------
module three_register_instruction_executor_top
	import trx_pkg::*;
#(
	parameter int REGISTER_COUNT = 3,
	parameter int MEMORY_DEPTH   = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  instr_t  instr,
	output logic    done,
	output result_t result
);

	localparam int MEM_SPAN = 1 << MEM_ADDR_W;
	localparam int MEM_USED = (MEMORY_DEPTH < MEM_SPAN) ? MEMORY_DEPTH : MEM_SPAN;
	localparam int MAW      = $clog2(MEM_USED);
	localparam int RAW      = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	exe_state_t state_q, state_d;
	instr_t cmd_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic ok_a_q, ok_b_q;
	logic done_q;
	result_t res_q, res_d;
	logic [REGISTER_COUNT-1:0] rvalid_q;
	logic [MEM_USED-1:0] mvalid_q;

	logic [RAW-1:0] ra_idx, rb_idx, rd_idx, reg_raddr;
	logic ra_ok, rb_ok, rd_ok, addr_ok;
	logic [MAW-1:0] mem_idx;
	logic [DATA_WIDTH-1:0] reg_rdata, mem_rdata, b_val, load_val, alu_a, alu_b;
	logic reg_we, mem_we, emit, alu_needed;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	alu_op_t alu_op_d;

	assign ra_idx  = RAW'(cmd_q.src_a_reg);
	assign rb_idx  = RAW'(cmd_q.src_b_reg);
	assign rd_idx  = RAW'(cmd_q.dest_reg);
	assign ra_ok   = (int'(cmd_q.src_a_reg) < REGISTER_COUNT);
	assign rb_ok   = (int'(cmd_q.src_b_reg) < REGISTER_COUNT);
	assign rd_ok   = (int'(cmd_q.dest_reg) < REGISTER_COUNT);
	assign addr_ok = (int'(cmd_q.mem_addr) < MEMORY_DEPTH);
	assign mem_idx = cmd_q.mem_addr[MAW-1:0];

	assign b_val    = ok_b_q ? reg_rdata : '0;
	assign load_val = (addr_ok && mvalid_q[mem_idx]) ? mem_rdata : '0;

	assign alu_needed = (cmd_q.command inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQU,
		CMD_LT, CMD_GT}) || (cmd_q.command == CMD_DIV && b_val != '0);

	always_comb begin
		case (cmd_q.command)
			CMD_SUB:         alu_op_d = ALU_SUB;
			CMD_MUL:         alu_op_d = ALU_MUL;
			CMD_DIV:         alu_op_d = ALU_DIV;
			CMD_EQU:         alu_op_d = ALU_EQ;
			CMD_LT, CMD_GT:  alu_op_d = ALU_LT;
			default:         alu_op_d = ALU_ADD;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  state_d = start ? S_RDA : S_IDLE;
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = S_OP;
			S_OP:    state_d = alu_needed ? S_WAIT : S_IDLE;
			S_WAIT:  state_d = alu_rsp.done ? S_IDLE : S_WAIT;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		reg_raddr = rb_idx;
		alu_req   = '0;
		alu_a     = a_q;
		alu_b     = b_val;
		emit      = 1'b0;
		res_d     = '0;
		reg_we    = 1'b0;
		mem_we    = 1'b0;
		case (state_q)
			S_RDA: reg_raddr = ra_idx;
			S_OP: begin
				if (alu_needed) begin
					alu_req.start = 1'b1;
					alu_req.op    = alu_op_d;
					// greater-than runs as less-than with swapped operands
					if (cmd_q.command == CMD_GT) begin
						alu_a = b_val;
						alu_b = a_q;
					end
				end else begin
					emit = 1'b1;
					case (cmd_q.command)
						CMD_DIV: res_d.divide_error = 1'b1;
						CMD_LOADIMM: begin
							res_d.written_value = cmd_q.immediate;
							reg_we              = rd_ok;
						end
						CMD_LOAD: begin
							res_d.written_value = load_val;
							reg_we              = rd_ok;
						end
						CMD_STORE: begin
							res_d.written_value = a_q;
							mem_we              = addr_ok;
						end
						CMD_JUMPZ: begin
							if (a_q == '0) begin
								res_d.jump_taken = 1'b1;
								res_d.next_index = cmd_q.jump_target;
							end
						end
						default: ;
					endcase
				end
			end
			S_WAIT: begin
				if (alu_rsp.done) begin
					emit                = 1'b1;
					res_d.written_value = alu_rsp.result;
					reg_we              = rd_ok;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			rvalid_q <= '0;
			mvalid_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (reg_we) begin
				rvalid_q[rd_idx] <= 1'b1;
			end
			if (mem_we) begin
				mvalid_q[mem_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= instr;
		end
		if (state_q == S_RDA) begin
			ok_a_q <= ra_ok && rvalid_q[ra_idx];
		end
		if (state_q == S_RDB) begin
			a_q    <= ok_a_q ? reg_rdata : '0;
			ok_b_q <= rb_ok && rvalid_q[rb_idx];
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	trx_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(REGISTER_COUNT)
	) u_regs (
		.clk  (clk),
		.we   (reg_we),
		.waddr(rd_idx),
		.wdata(res_d.written_value),
		.raddr(reg_raddr),
		.rdata(reg_rdata)
	);

	trx_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MEM_USED)
	) u_dmem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_idx),
		.wdata(a_q),
		.raddr(mem_idx),
		.rdata(mem_rdata)
	);

	trx_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (alu_a),
		.b     (alu_b),
		.rsp   (alu_rsp)
	);

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hw/rtl/trx_ram.sv
// ----------------------------------------------------------------------------
// trx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/trx_alu.sv
// ----------------------------------------------------------------------------
// trx_alu
// Iterative arithmetic unit built around one shared adder/subtractor:
// add, subtract, equal and signed less-than in one pass, shift-add multiply
// and restoring divide one bit per cycle.
// ----------------------------------------------------------------------------
module trx_alu
	import trx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  alu_req_t              req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output alu_rsp_t              rsp
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

	alu_state_t st_q, st_d;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	alu_op_t op_q;
	logic neg_q;
	logic [DATA_WIDTH-1:0] x_q, y_q, z_q, res_q;

	logic [DATA_WIDTH-1:0] add_x, add_y, diff, rem_shift, single_res;
	logic add_sub;
	logic [DATA_WIDTH:0] sum;
	logic ovf, lt, eq, last;

	assign last      = (cnt_q == LAST);
	assign rem_shift = {x_q[DATA_WIDTH-2:0], z_q[DATA_WIDTH-1]};

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			A_IDLE: begin
				if (req.start) begin
					case (req.op)
						ALU_MUL: st_d = A_MUL;
						ALU_DIV: st_d = A_MAGA;
						default: st_d = A_SINGLE;
					endcase
				end
			end
			A_SINGLE: st_d = A_IDLE;
			A_MUL:    st_d = last ? A_IDLE : A_MUL;
			A_MAGA:   st_d = A_MAGB;
			A_MAGB:   st_d = A_DIV;
			A_DIV:    st_d = last ? A_FIX : A_DIV;
			A_FIX:    st_d = A_IDLE;
			default:  st_d = A_IDLE;
		endcase
	end

	// shared adder operand select
	always_comb begin
		add_x   = x_q;
		add_y   = y_q;
		add_sub = 1'b0;
		case (st_q)
			A_SINGLE: add_sub = (op_q != ALU_ADD);
			A_MUL:    add_y = z_q[0] ? y_q : '0;
			A_MAGA: begin
				add_x   = '0;
				add_y   = x_q;
				add_sub = 1'b1;
			end
			A_MAGB: begin
				add_x   = '0;
				add_sub = 1'b1;
			end
			A_DIV: begin
				add_x   = rem_shift;
				add_sub = 1'b1;
			end
			A_FIX: begin
				add_x   = '0;
				add_y   = z_q;
				add_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign sum  = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
		+ {{DATA_WIDTH{1'b0}}, add_sub};
	assign diff = sum[DATA_WIDTH-1:0];
	assign ovf  = (x_q[DATA_WIDTH-1] != y_q[DATA_WIDTH-1])
		&& (diff[DATA_WIDTH-1] != x_q[DATA_WIDTH-1]);
	assign lt   = diff[DATA_WIDTH-1] ^ ovf;
	assign eq   = (diff == '0);

	always_comb begin
		case (op_q)
			ALU_EQ:  single_res = {{(DATA_WIDTH-1){1'b0}}, eq};
			ALU_LT:  single_res = {{(DATA_WIDTH-1){1'b0}}, lt};
			default: single_res = diff;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= (st_q == A_MUL || st_q == A_DIV) ? cnt_q + 1'b1 : '0;
			done_q <= (st_q == A_SINGLE) || (st_q == A_MUL && last) || (st_q == A_FIX);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			A_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
					if (req.op == ALU_MUL) begin
						x_q <= '0;
						y_q <= a;
						z_q <= b;
					end else begin
						x_q <= a;
						y_q <= b;
						z_q <= '0;
					end
				end
			end
			A_SINGLE: res_q <= single_res;
			A_MUL: begin
				// accumulate low product bits only, wrap is implied
				x_q <= diff;
				y_q <= y_q << 1;
				z_q <= z_q >> 1;
				if (last) begin
					res_q <= diff;
				end
			end
			A_MAGA: z_q <= x_q[DATA_WIDTH-1] ? diff : x_q;
			A_MAGB: begin
				if (y_q[DATA_WIDTH-1]) begin
					y_q <= diff;
				end
				x_q <= '0;
			end
			A_DIV: begin
				// carry out means no borrow: quotient bit is one
				x_q <= sum[DATA_WIDTH] ? diff : rem_shift;
				z_q <= {z_q[DATA_WIDTH-2:0], sum[DATA_WIDTH]};
			end
			A_FIX: res_q <= neg_q ? diff : z_q;
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// File: hw/rtl/trx_chk.sv
// ----------------------------------------------------------------------------
// trx_chk
// Port-level checks of the executor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module trx_chk
	import trx_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after accept");

	// the block goes idle only by delivering a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_no_jump_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.jump_taken |-> result.next_index == '0)
		else $error("next_index set without a taken jump");

	a_div_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_error |-> result.written_value == '0 && !result.jump_taken)
		else $error("divide error with a written value or jump");

endmodule

bind three_register_instruction_executor_top trx_chk u_chk (.*);
